FILE: src/emoe_pkg.sv
// ----------------------------------------------------------------------------
// emoe_pkg
// Shared types and codes for the extent map overwrite engine.
// ----------------------------------------------------------------------------
package emoe_pkg;

  localparam int DW = 48;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_SPACE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_MAP    = 2'd1;
  localparam logic [1:0] KIND_GAP    = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SPACE,
    OP_ADD_STEP,
    OP_COMMIT,
    OP_RD_STEP,
    OP_EMIT
  } emoe_op_t;

  typedef struct packed {
    emoe_op_t   op;
    logic [1:0] st;
  } emoe_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       ovf_add;
    logic       ovf_rd;
    logic       zero_len;
    logic       add_done;
    logic       full;
    logic       rd_done;
    logic       out_free;
  } emoe_stat_t;

endpackage

FILE: src/emoe_ctrl.sv
// ----------------------------------------------------------------------------
// emoe_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module emoe_ctrl
  import emoe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  emoe_stat_t stat,
  output emoe_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ADD,
    S_COMMIT,
    S_READ,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [1:0] st_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.op = OP_NOP;
    cmd.st = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_DEC: begin
        if (stat.action == ACT_SPACE) cmd.op = OP_SPACE;
      end
      S_ADD: begin
        if (!stat.add_done) cmd.op = OP_ADD_STEP;
      end
      S_COMMIT: cmd.op = OP_COMMIT;
      S_READ: begin
        if (!stat.rd_done && stat.out_free) cmd.op = OP_RD_STEP;
      end
      S_EMIT: begin
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_DEC;
        end
        S_DEC: begin
          case (stat.action)
            ACT_ADD: begin
              if (stat.ovf_add) begin
                st_r    <= ST_OVF;
                state_r <= S_EMIT;
              end else if (!stat.zero_len) begin
                st_r    <= ST_OK;
                state_r <= S_ADD;
              end else begin
                st_r    <= ST_OK;
                state_r <= S_EMIT;
              end
            end
            ACT_READ: begin
              if (stat.ovf_rd) begin
                st_r    <= ST_OVF;
                state_r <= S_EMIT;
              end else if (!stat.zero_len) begin
                st_r    <= ST_OK;
                state_r <= S_READ;
              end else begin
                st_r    <= ST_OK;
                state_r <= S_EMIT;
              end
            end
            default: begin
              st_r    <= ST_OK;
              state_r <= S_EMIT;
            end
          endcase
        end
        S_ADD: begin
          if (stat.add_done) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          st_r    <= stat.full ? ST_FULL : ST_OK;
          state_r <= S_EMIT;
        end
        S_READ: begin
          if (stat.rd_done) state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/emoe_dp.sv
// ----------------------------------------------------------------------------
// emoe_dp
// Extent table (two banks), request registers, scan arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module emoe_dp
  import emoe_pkg::*;
#(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  emoe_cmd_t     cmd,
  output emoe_stat_t    stat,
  input  logic [1:0]    in_action,
  input  logic [DW-1:0] in_file_offset,
  input  logic [DW-1:0] in_phys_addr,
  input  logic [DW-1:0] in_length,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [1:0]    out_segment_kind,
  output logic [DW-1:0] out_seg_file_offset,
  output logic [DW-1:0] out_seg_phys_addr,
  output logic [DW-1:0] out_seg_length,
  output logic [DW-1:0] out_mapped_total,
  output logic [DW-1:0] out_space_total,
  output logic          out_last
);

  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int WW = $clog2(MAX_EXTENTS + 3);
  localparam int FW = (ADDR_BITS > DW) ? DW + 1 : DW;
  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  logic [FW-1:0] fmem [2][MAX_EXTENTS];
  logic [DW-1:0] pmem [2][MAX_EXTENTS];
  logic [FW-1:0] lmem [2][MAX_EXTENTS];

  logic [1:0]    act_r;
  logic [DW-1:0] fo_r, pa_r, ln_r;
  logic          bank_r;
  logic [CW-1:0] count_r, i_r;
  logic [WW-1:0] w_r;
  logic          phase_r, ins_r;
  logic [FW-1:0] cur_r;
  logic [DW-1:0] total_r, mapped_r, space_r;

  logic [DW:0]   chk_f, chk_p, sp_sum;
  logic [FW-1:0] a, b, rs, rl, e, lo, hi;
  logic [DW-1:0] rp;
  logic [IW-1:0] idx;
  logic          at_end, ovl, out_free;

  logic          cand_v, adv, ph_set, ins_now, wr_v;
  logic [FW-1:0] cand_f, cand_l, wr_f, wr_l;
  logic [DW-1:0] cand_p, wr_p;

  logic          emit;
  logic [1:0]    em_st, em_kind;
  logic [FW-1:0] em_fo, em_len;
  logic [DW-1:0] em_pa;
  logic          em_last;

  assign chk_f  = {1'b0, fo_r} + {1'b0, ln_r};
  assign chk_p  = {1'b0, pa_r} + {1'b0, ln_r};
  assign sp_sum = {1'b0, space_r} + {1'b0, ln_r};
  assign a      = FW'(fo_r);
  assign b      = FW'(chk_f);
  assign idx    = i_r[IW-1:0];
  assign rs     = fmem[bank_r][idx];
  assign rp     = pmem[bank_r][idx];
  assign rl     = lmem[bank_r][idx];
  assign e      = rs + rl;
  assign at_end = (i_r == count_r);
  assign ovl    = (e > a) && (rs < b);
  assign lo     = (rs > a) ? rs : a;
  assign hi     = (e < b) ? e : b;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.action   = act_r;
    stat.ovf_add  = (64'(chk_f) > ADDR_MASK) || (64'(chk_p) > ADDR_MASK);
    stat.ovf_rd   = (64'(chk_f) > ADDR_MASK);
    stat.zero_len = (ln_r == '0);
    stat.add_done = at_end && ins_r;
    stat.full     = (w_r > WW'(MAX_EXTENTS));
    stat.rd_done  = at_end && !(cur_r < b);
    stat.out_free = out_free;
  end

  // one add step of trim/split work: a whole entry, one half of an overlapped entry, or the insert
  always_comb begin
    cand_v  = 1'b0;
    cand_f  = rs;
    cand_p  = rp;
    cand_l  = rl;
    adv     = 1'b0;
    ph_set  = phase_r;
    ins_now = 1'b0;
    if (at_end) begin
      ins_now = !ins_r;
    end else if (!ovl) begin
      cand_v = 1'b1;
      adv    = 1'b1;
    end else if (!phase_r) begin
      ph_set = 1'b1;
      if (rs < a) begin
        cand_v = 1'b1;
        cand_l = a - rs;
      end
    end else begin
      ph_set = 1'b0;
      adv    = 1'b1;
      if (e > b) begin
        cand_v = 1'b1;
        cand_f = b;
        cand_p = rp + DW'(b - rs);
        cand_l = e - b;
      end
    end
    if (cand_v && !ins_r && (cand_f >= a)) ins_now = 1'b1;
    wr_v = (cmd.op == OP_ADD_STEP) && (ins_now || cand_v);
    wr_f = ins_now ? a : cand_f;
    wr_p = ins_now ? pa_r : cand_p;
    wr_l = ins_now ? FW'(ln_r) : cand_l;
  end

  always_comb begin
    emit    = 1'b0;
    em_st   = ST_OK;
    em_kind = KIND_STATUS;
    em_fo   = '0;
    em_pa   = '0;
    em_len  = '0;
    em_last = 1'b0;
    if (cmd.op == OP_EMIT) begin
      emit    = 1'b1;
      em_st   = cmd.st;
      em_last = 1'b1;
    end else if (cmd.op == OP_RD_STEP) begin
      if (at_end) begin
        emit    = (cur_r < b);
        em_kind = KIND_GAP;
        em_fo   = cur_r;
        em_len  = b - cur_r;
        em_last = 1'b1;
      end else if (ovl && (lo > cur_r)) begin
        emit    = 1'b1;
        em_kind = KIND_GAP;
        em_fo   = cur_r;
        em_len  = lo - cur_r;
      end else if (ovl) begin
        emit    = 1'b1;
        em_kind = KIND_MAP;
        em_fo   = lo;
        em_pa   = rp + DW'(lo - rs);
        em_len  = hi - lo;
        em_last = (hi == b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_v && (w_r < WW'(MAX_EXTENTS))) begin
      fmem[!bank_r][w_r[IW-1:0]] <= wr_f;
      pmem[!bank_r][w_r[IW-1:0]] <= wr_p;
      lmem[!bank_r][w_r[IW-1:0]] <= wr_l;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      fo_r <= in_file_offset;
      pa_r <= in_phys_addr;
      ln_r <= in_length;
    end
    if (emit) begin
      out_status          <= em_st;
      out_segment_kind    <= em_kind;
      out_seg_file_offset <= em_fo[DW-1:0];
      out_seg_phys_addr   <= em_pa;
      out_seg_length      <= em_len[DW-1:0];
      out_mapped_total    <= mapped_r;
      out_space_total     <= space_r;
      out_last            <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= ACT_ADD;
      bank_r    <= 1'b0;
      count_r   <= '0;
      i_r       <= '0;
      w_r       <= '0;
      phase_r   <= 1'b0;
      ins_r     <= 1'b0;
      cur_r     <= '0;
      total_r   <= '0;
      mapped_r  <= '0;
      space_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (wr_v) begin
        w_r     <= w_r + WW'(1);
        total_r <= total_r + wr_l[DW-1:0];
      end
      case (cmd.op)
        OP_LOAD: begin
          act_r   <= in_action;
          i_r     <= '0;
          w_r     <= '0;
          phase_r <= 1'b0;
          ins_r   <= 1'b0;
          cur_r   <= FW'(in_file_offset);
          total_r <= '0;
        end
        OP_SPACE: space_r <= sp_sum[DW] ? {DW{1'b1}} : sp_sum[DW-1:0];
        OP_ADD_STEP: begin
          if (ins_now) begin
            ins_r <= 1'b1;
          end else begin
            phase_r <= ph_set;
            if (adv) i_r <= i_r + CW'(1);
          end
        end
        OP_COMMIT: begin
          if (w_r <= WW'(MAX_EXTENTS)) begin
            bank_r   <= !bank_r;
            count_r  <= CW'(w_r);
            mapped_r <= total_r;
          end
        end
        OP_RD_STEP: begin
          if (at_end) cur_r <= b;
          else if (ovl && (lo > cur_r)) cur_r <= lo;
          else if (ovl) begin
            cur_r <= hi;
            i_r   <= i_r + CW'(1);
          end else i_r <= i_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EXTENTS))
    else $error("extent count above table size");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMMIT && !stat.full) |=> (count_r == CW'($past(w_r))))
    else $error("commit lost entry count");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RD_STEP) |-> (cur_r <= b))
    else $error("read cursor past range end");

endmodule

FILE: src/extent_map_overwrite_engine.sv
// ----------------------------------------------------------------------------
// extent_map_overwrite_engine
// Sorted extent table with overwrite-on-add, space accounting and ranged
// read-out of mapped segments and zero-fill gaps.
// ----------------------------------------------------------------------------
// One request at a time. Add-space and rejected or empty requests go straight
// to the status beat. Add-extent walks the table one step a cycle, one or two
// steps per stored extent plus insert, done and commit; the new table is built
// in the spare bank and swapped in on commit unless it overflows, which gives
// status full. A read takes one step per stored extent plus one per zero-fill
// gap beat, and stalls with the output. Every request gives exactly one beat
// with tlast, except a read, which gives its segments in file order.
module extent_map_overwrite_engine
  import emoe_pkg::*;
#(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // file_offset, phys_addr, length
  input  logic [1:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [247:0] out_tdata,  // status, seg_file_offset, seg_phys_addr,
                                   // seg_length, mapped_total, space_total
  output logic [1:0]   out_tuser,  // segment_kind
  output logic         out_tlast
);

  emoe_cmd_t     cmd;
  emoe_stat_t    stat;
  logic [1:0]    o_st;
  logic [DW-1:0] o_fo, o_pa, o_len, o_map, o_sp;

  emoe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  emoe_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_action           (in_tuser),
    .in_file_offset      (in_tdata[47:0]),
    .in_phys_addr        (in_tdata[95:48]),
    .in_length           (in_tdata[143:96]),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_status          (o_st),
    .out_segment_kind    (out_tuser),
    .out_seg_file_offset (o_fo),
    .out_seg_phys_addr   (o_pa),
    .out_seg_length      (o_len),
    .out_mapped_total    (o_map),
    .out_space_total     (o_sp),
    .out_last            (out_tlast)
  );

  assign out_tdata = {6'd0, o_sp, o_map, o_len, o_pa, o_fo, o_st};

endmodule
